[rtl/b64e_pkg.sv]
`timescale 1ns / 1ps

package b64e_pkg;

    // ASCII padding character
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Default number of queue entries between front and back
    localparam int QUEUE_DEPTH = 2;

    // One classified byte: up to four characters and where they end
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      last_idx;
        logic            fin;
    } t_entry;

    // Map a 6-bit code to the standard base64 alphabet
    function automatic logic [7:0] b64_char(input logic [5:0] six);
        logic [7:0] six_w;
        six_w = {2'b00, six};
        if (six < 6'd26) begin
            return 8'h41 + six_w;
        end else if (six < 6'd52) begin
            return 8'h61 + six_w - 8'd26;
        end else if (six < 6'd62) begin
            return 8'h30 + six_w - 8'd52;
        end else if (six == 6'd62) begin
            return 8'h2B;
        end else begin
            return 8'h2F;
        end
    endfunction

endpackage

[rtl/b64e_if.sv]
`timescale 1ns / 1ps

// Byte channel: one message byte per transfer
interface b64e_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

// Character channel: one encoded character per transfer
interface b64e_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       final_char;

    modport source (output valid, output char_code, output final_char, input ready);
    modport sink   (input valid, input char_code, input final_char, output ready);
endinterface

[rtl/base64_stream_encoder.sv]
`timescale 1ns / 1ps

// Streaming base64 encoder, standard alphabet with '=' padding.
// i_byte: one message byte per transfer; final_byte marks the last byte.
// o_char: one ASCII character per transfer; final_char marks the last one.
// The front classifies each byte by its place in a 3-byte group and builds
// the characters it completes (one or two, or two to four on a final byte,
// padded with '=' when the group is short). A small entry queue feeds the
// back, which sends one character per cycle from an output register while
// the receiver is ready. A byte's characters pass the queue, then that register.
// Throughput: a byte is taken each cycle while the queue has room; the
// output port sends four characters per three bytes, so over a long
// message the output port sets the pace.
// An empty message yields nothing. After a final byte the group state is
// back to its start, so the next message follows at once.
// Reset clears group state, queue and output valid. When the receiver
// stalls, the character on o_char holds; bytes are still taken until the
// queue is full.
module base64_stream_encoder #(
    parameter int QueueDepth = b64e_pkg::QUEUE_DEPTH
) (
    input logic         i_clk,
    input logic         i_rst_n,
    b64e_byte_if.sink   i_byte,
    b64e_char_if.source o_char
);
    import b64e_pkg::*;

    t_entry w_push_entry, w_head_entry;
    logic   w_push, w_room, w_pop, w_avail;

    b64e_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_byte.valid),
        .o_ready      (i_byte.ready),
        .i_data_byte  (i_byte.data_byte),
        .i_final_byte (i_byte.final_byte),
        .o_push       (w_push),
        .o_entry      (w_push_entry),
        .i_room       (w_room)
    );

    b64e_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_room  (w_room),
        .i_pop   (w_pop),
        .o_avail (w_avail),
        .o_entry (w_head_entry)
    );

    b64e_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_avail      (w_avail),
        .i_entry      (w_head_entry),
        .o_pop        (w_pop),
        .o_valid      (o_char.valid),
        .i_ready      (o_char.ready),
        .o_char_code  (o_char.char_code),
        .o_final_char (o_char.final_char)
    );

endmodule

[rtl/b64e_front.sv]
`timescale 1ns / 1ps

module b64e_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_data_byte,
    input  logic             i_final_byte,
    output logic             o_push,
    output b64e_pkg::t_entry o_entry,
    input  logic             i_room
);
    import b64e_pkg::*;

    localparam logic [1:0] PH_0 = 2'd0;
    localparam logic [1:0] PH_1 = 2'd1;
    localparam logic [1:0] PH_2 = 2'd2;

    logic [1:0] r_phase, n_phase;
    logic [3:0] r_carry, n_carry;
    logic       w_take;

    assign o_ready = i_room;
    assign w_take  = i_valid && i_room;
    assign o_push  = w_take;

    // Classify the byte against the group phase and build its characters
    always_comb begin
        o_entry          = '0;
        o_entry.chars[2] = PAD_CHAR;
        o_entry.chars[3] = PAD_CHAR;
        n_phase          = r_phase;
        n_carry          = r_carry;
        case (r_phase)
            PH_1: begin
                o_entry.chars[0] = b64_char({r_carry[1:0], i_data_byte[7:4]});
                o_entry.chars[1] = b64_char({i_data_byte[3:0], 2'b00});
                if (i_final_byte) begin
                    o_entry.last_idx = 2'd2;
                    o_entry.fin      = 1'b1;
                    n_phase          = PH_0;
                    n_carry          = 4'd0;
                end else begin
                    o_entry.last_idx = 2'd0;
                    n_phase          = PH_2;
                    n_carry          = i_data_byte[3:0];
                end
            end
            PH_2: begin
                o_entry.chars[0] = b64_char({r_carry, i_data_byte[7:6]});
                o_entry.chars[1] = b64_char(i_data_byte[5:0]);
                o_entry.last_idx = 2'd1;
                o_entry.fin      = i_final_byte;
                n_phase          = PH_0;
                n_carry          = 4'd0;
            end
            default: begin
                o_entry.chars[0] = b64_char(i_data_byte[7:2]);
                o_entry.chars[1] = b64_char({i_data_byte[1:0], 4'b0000});
                if (i_final_byte) begin
                    o_entry.last_idx = 2'd3;
                    o_entry.fin      = 1'b1;
                    n_phase          = PH_0;
                    n_carry          = 4'd0;
                end else begin
                    o_entry.last_idx = 2'd0;
                    n_phase          = PH_1;
                    n_carry          = {2'b00, i_data_byte[1:0]};
                end
            end
        endcase
    end

    // Advance phase and carry on each byte transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_0;
            r_carry <= 4'd0;
        end else if (w_take) begin
            r_phase <= n_phase;
            r_carry <= n_carry;
        end
    end

endmodule

[rtl/b64e_queue.sv]
`timescale 1ns / 1ps

module b64e_queue #(
    parameter int Depth = b64e_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  b64e_pkg::t_entry i_entry,
    output logic             o_room,
    input  logic             i_pop,
    output logic             o_avail,
    output b64e_pkg::t_entry o_entry
);
    import b64e_pkg::*;

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CW = $clog2(Depth + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(Depth - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(Depth);

    t_entry          r_mem [Depth];
    logic [AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            w_wr, w_rd;

    assign o_room  = (r_count != FULL_CNT);
    assign o_avail = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign w_wr    = i_push && o_room;
    assign w_rd    = i_pop && o_avail;

    // Store pushed entries
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Advance pointers and track fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[rtl/b64e_back.sv]
`timescale 1ns / 1ps

module b64e_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_avail,
    input  b64e_pkg::t_entry i_entry,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_char_code,
    output logic             o_final_char
);
    import b64e_pkg::*;

    t_entry     r_cur;
    logic       r_busy;
    logic [1:0] r_idx;
    logic       w_xfer, w_at_end;

    assign o_valid      = r_busy;
    assign w_xfer       = r_busy && i_ready;
    assign w_at_end     = (r_idx == r_cur.last_idx);
    assign o_pop        = i_avail && (!r_busy || (w_xfer && w_at_end));
    assign o_char_code  = r_cur.chars[r_idx];
    assign o_final_char = r_cur.fin && w_at_end;

    // Hold the current entry; step one character per transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (w_xfer) begin
            if (w_at_end) begin
                r_busy <= 1'b0;
                r_idx  <= 2'd0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    // Load the next entry payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_entry;
        end
    end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import b64e_pkg::*;

    // Byte positions within a 3-byte group
    localparam logic [1:0] GRP_FIRST  = 2'd0;
    localparam logic [1:0] GRP_SECOND = 2'd1;
    localparam logic [1:0] GRP_THIRD  = 2'd2;

    localparam int RESET_CYCLES     = 10;
    localparam int DRAIN_CYCLES     = 20;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int RANDOM_PER_PHASE = 86;
    localparam int NUM_PHASES       = 4;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } enc_char_t;

    typedef struct {
        logic [7:0] data;
        logic       fin;
        string      chars;   // empty: take the expectation from the encoder model
    } byte_row_t;

    logic clk;
    logic rst_n;

    b64e_byte_if byte_ch ();
    b64e_char_if char_ch ();

    base64_stream_encoder u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_byte  (byte_ch),
        .o_char  (char_ch)
    );

    string       b64_alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    logic [1:0]  grp_pos;
    logic [3:0]  grp_carry;
    enc_char_t   fresh_chars[$];
    enc_char_t   expected_chars[$];
    byte_row_t   directed_rows[$];
    int          src_idle_pct;
    int          sink_stall_pct;
    int          err_count;
    int          chars_checked;
    int          bytes_sent;
    int          msgs_sent;
    int          cycle_count;

    // Clock
    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Encode one byte into fresh_chars and advance the group state
    task automatic encode_byte(input logic [7:0] b, input logic fin);
        fresh_chars.delete();
        case (grp_pos)
            GRP_SECOND: begin
                fresh_chars.push_back({b64_alphabet[{grp_carry[1:0], b[7:4]}], 1'b0});
                if (fin) begin
                    fresh_chars.push_back({b64_alphabet[{b[3:0], 2'b00}], 1'b0});
                    fresh_chars.push_back({PAD_CHAR, 1'b1});
                end else begin
                    grp_carry = b[3:0];
                    grp_pos   = GRP_THIRD;
                end
            end
            GRP_THIRD: begin
                fresh_chars.push_back({b64_alphabet[{grp_carry, b[7:6]}], 1'b0});
                fresh_chars.push_back({b64_alphabet[b[5:0]], fin});
                grp_carry = 4'd0;
                grp_pos   = GRP_FIRST;
            end
            default: begin
                // an unused position value counts as the start of a group
                fresh_chars.push_back({b64_alphabet[b[7:2]], 1'b0});
                if (fin) begin
                    fresh_chars.push_back({b64_alphabet[{b[1:0], 4'b0000}], 1'b0});
                    fresh_chars.push_back({PAD_CHAR, 1'b0});
                    fresh_chars.push_back({PAD_CHAR, 1'b1});
                end else begin
                    grp_carry = {2'b00, b[1:0]};
                    grp_pos   = GRP_SECOND;
                end
            end
        endcase
        if (fin) begin
            grp_pos   = GRP_FIRST;
            grp_carry = 4'd0;
        end
    endtask

    // Drive one byte and hold it until the transfer; valid stays high afterwards
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid      <= 1'b1;
        byte_ch.data_byte  <= b;
        byte_ch.final_byte <= fin;
        @(posedge clk);
        while (!byte_ch.ready) @(posedge clk);
        bytes_sent++;
    endtask

    // Queue the model's characters for a byte, then send it
    task automatic play_byte(input logic [7:0] b, input logic fin);
        encode_byte(b, fin);
        foreach (fresh_chars[i]) expected_chars.push_back(fresh_chars[i]);
        send_byte(b, fin);
    endtask

    function automatic void add_row(input logic [7:0] b, input logic fin, input string s);
        byte_row_t row;
        row.data  = b;
        row.fin   = fin;
        row.chars = s;
        directed_rows.push_back(row);
    endfunction

    // Receiver: stall at random
    always @(posedge clk) begin
        char_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Check each character transfer against the oldest expectation
    always @(posedge clk) begin
        enc_char_t want;
        if (rst_n && char_ch.valid && char_ch.ready) begin
            if (expected_chars.size() == 0) begin
                err_count++;
                $display("%0t: unexpected char: expected none, actual 0x%02h final %0b",
                         $time, char_ch.char_code, char_ch.final_char);
            end else begin
                want = expected_chars.pop_front();
                chars_checked++;
                if (char_ch.char_code !== want.code) begin
                    err_count++;
                    $display("%0t: char_code mismatch: expected 0x%02h, actual 0x%02h",
                             $time, want.code, char_ch.char_code);
                end
                if (char_ch.final_char !== want.last) begin
                    err_count++;
                    $display("%0t: final_char mismatch: expected %0b, actual %0b",
                             $time, want.last, char_ch.final_char);
                end
            end
        end
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // Stimulus
    initial begin
        int          src_pct[NUM_PHASES];
        int          sink_pct[NUM_PHASES];
        int          phase_bytes;
        int          msg_len;
        logic [7:0]  b;
        logic        fin;
        byte_row_t   row;

        src_pct  = '{0, 60, 0, 32};
        sink_pct = '{0, 0, 60, 32};

        rst_n              = 1'b0;
        byte_ch.valid      = 1'b0;
        byte_ch.data_byte  = 8'h00;
        byte_ch.final_byte = 1'b0;
        char_ch.ready      = 1'b0;
        src_idle_pct       = 0;
        sink_stall_pct     = 0;
        err_count          = 0;
        chars_checked      = 0;
        bytes_sent         = 0;
        msgs_sent          = 0;
        grp_pos            = GRP_FIRST;
        grp_carry          = 4'd0;

        // single-byte messages at both extremes
        add_row(8'h00, 1'b1, "AA==");
        add_row(8'hFF, 1'b1, "/w==");
        // two-byte message, flush from the second position
        add_row(8'h00, 1'b0, "A");
        add_row(8'h00, 1'b1, "AA=");
        // full group of ones, final on the third byte
        add_row(8'hFF, 1'b0, "/");
        add_row(8'hFF, 1'b0, "/");
        add_row(8'hFF, 1'b1, "//");
        // classic three-letter group, then a two-byte message of ones
        add_row(8'h4D, 1'b0, "T");
        add_row(8'h61, 1'b0, "W");
        add_row(8'h6E, 1'b1, "Fu");
        add_row(8'hFF, 1'b0, "/");
        add_row(8'hFF, 1'b1, "/8=");
        // group wrap, then flush from the first position
        add_row(8'h00, 1'b0, "A");
        add_row(8'h00, 1'b0, "A");
        add_row(8'h00, 1'b0, "AA");
        add_row(8'hFB, 1'b1, "+w==");
        // alternating bit patterns in a six-byte and a two-byte message
        add_row(8'hA5, 1'b0, "");
        add_row(8'h5A, 1'b0, "");
        add_row(8'h3C, 1'b0, "");
        add_row(8'hC3, 1'b0, "");
        add_row(8'h0F, 1'b0, "");
        add_row(8'hF0, 1'b1, "");
        add_row(8'h96, 1'b0, "");
        add_row(8'h69, 1'b1, "");

        // Hold reset; no bytes sent, so nothing may come out
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.chars.len() == 0) begin
                play_byte(row.data, row.fin);
            end else begin
                encode_byte(row.data, row.fin);
                for (int k = 0; k < row.chars.len(); k++) begin
                    expected_chars.push_back({row.chars[k],
                                              row.fin && (k == row.chars.len() - 1)});
                end
                send_byte(row.data, row.fin);
            end
            if (row.fin) msgs_sent++;
        end

        // Random messages under each idling mix
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            src_idle_pct   = src_pct[ph];
            sink_stall_pct = sink_pct[ph];
            phase_bytes    = 0;
            while (phase_bytes < RANDOM_PER_PHASE) begin
                msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24)
                                                       : $urandom_range(1, 6);
                for (int k = 0; k < msg_len; k++) begin
                    case ($urandom_range(0, 9))
                        0:       b = 8'h00;
                        1:       b = 8'hFF;
                        default: b = 8'($urandom_range(0, 255));
                    endcase
                    fin = (k == msg_len - 1);
                    play_byte(b, fin);
                end
                phase_bytes += msg_len;
                msgs_sent++;
            end
        end
        byte_ch.valid <= 1'b0;

        // Drain the output, then allow for trailing activity
        while (expected_chars.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Encoded %0d bytes in %0d messages over four idle/stall mixes;",
                 bytes_sent, msgs_sent);
        $display("checked %0d characters, %0d mismatches.", chars_checked, err_count);
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
